FILE: hdl/loss_and_gradient_unit_macros.svh
// Assertion macros for the loss and gradient unit.
`ifndef LOSS_AND_GRADIENT_UNIT_MACROS_SVH
`define LOSS_AND_GRADIENT_UNIT_MACROS_SVH

// same-cycle implication
`define LGU_ASSERT_IMP(lbl, ck, rn, ant, con) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (con)) \
		else $error("lgu assertion failed");

// next-cycle implication
`define LGU_ASSERT_NXT(lbl, ck, rn, ant, con) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (con)) \
		else $error("lgu assertion failed");

`endif

FILE: hdl/lgu_pkg.sv
// Shared types, constants and the log table function of the loss and gradient unit.
package lgu_pkg;

	localparam int FRAC_BITS_DEF   = 12;
	localparam int LOG_ENTRIES_DEF = 1024;
	localparam int COST_W          = 47;
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;

	typedef struct packed {
		logic signed [15:0] o;
		logic signed [15:0] e;
		logic               last;
		logic               mode;
		logic               dom;
	} item_t;

	// ln(1 + (2k+1)/2^(lw+1)) in Q32 via bitwise log2
	function automatic logic [31:0] ln_entry(int unsigned k, int unsigned lw);
		logic [63:0] y;
		logic [63:0] lg;
		logic [63:0] r;
		y  = (64'd1 << 30) + (64'(2 * k + 1) << (29 - lw));
		lg = 64'd0;
		for (int i = 0; i < 32; i++) begin
			y  = (y * y) >> 30;
			lg = lg << 1;
			if (y >= (64'd2 << 30)) begin
				y  = y >> 1;
				lg = lg | 64'd1;
			end
		end
		r = (lg * LN2_Q32 + (64'd1 << 31)) >> 32;
		return r[31:0];
	endfunction

endpackage

FILE: hdl/lgu_fifo.sv
// Small register queue between the front and back parts.
module lgu_fifo #(
	parameter int W     = 35,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end
endmodule

FILE: hdl/lgu_front.sv
// Front part: mode register, word intake, domain classification and the queue.
module lgu_front #(
	parameter int FRAC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [15:0]  output_value,
	input  logic signed [15:0]  expected_value,
	input  logic                last_item,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                q_pop,
	output logic                q_empty,
	output lgu_pkg::item_t      q_item
);
	import lgu_pkg::*;

	localparam logic signed [16:0] ONE = 17'(1 << FRAC_BITS);

	logic  mode_q;
	item_t in_item;
	logic  [16:0] o_ext;

	assign o_ext        = {output_value[15], output_value};
	assign in_item.o    = output_value;
	assign in_item.e    = expected_value;
	assign in_item.last = last_item;
	assign in_item.mode = mode_q;
	assign in_item.dom  = mode_q && (($signed(o_ext) <= 17'sd0) || ($signed(o_ext) >= ONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	lgu_fifo #(.W($bits(item_t)), .DEPTH(2)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (in_item),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_item),
		.empty   (q_empty)
	);
endmodule

FILE: hdl/lgu_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
module lgu_div #(
	parameter int NW = 41,
	parameter int DW = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [NW-1:0]                  dividend,
	input  logic [DW-1:0]                  divisor,
	output logic                           done,
	output logic [2*((NW + 1) / 2)-1:0]    quotient
);
	localparam int ITER = (NW + 1) / 2;
	localparam int QW   = 2 * ITER;
	localparam int CW   = $clog2(ITER + 1);

	logic [DW:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   rem_n;
	logic [QW-1:0] quo_n;

	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < 2; i++) begin
			rem_n = {rem_n[DW-1:0], quo_n[QW-1]};
			quo_n = {quo_n[QW-2:0], 1'b0};
			if (rem_n >= {1'b0, divisor}) begin
				rem_n    = rem_n - {1'b0, divisor};
				quo_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ITER);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= QW'(dividend);
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

FILE: hdl/lgu_back.sv
// Back part: gradient, log lookups, cost term, accumulation and result register.
module lgu_back #(
	parameter int FRAC_BITS   = 12,
	parameter int LOG_ENTRIES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  lgu_pkg::item_t               q_item,
	output logic                         q_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [31:0]           gradient,
	output logic                         gradient_saturated,
	output logic                         domain_error,
	output logic [lgu_pkg::COST_W-1:0]   cost_total,
	output logic                         cost_last
);
	import lgu_pkg::*;

	localparam int F    = FRAC_BITS;
	localparam int LW   = $clog2(LOG_ENTRIES);
	localparam int NW   = 17 + 2 * F;
	localparam int DW   = 2 * F;
	localparam int QW   = 2 * ((NW + 1) / 2);
	localparam int NLW  = F + 5;
	localparam int P1W  = 17 + NLW;
	localparam int P2W  = 19 + NLW;
	localparam int SW   = P2W + 1;
	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_DEN, S_DIVGO, S_DIV, S_LIDX, S_LROM, S_LNL, S_MUL, S_SUM, S_ACC
	} state_t;

	state_t state_q;

	logic [31:0] ln_tab [LOG_ENTRIES];
	for (genvar k = 0; k < LOG_ENTRIES; k++) begin : g_tab
		localparam logic [31:0] V = ln_entry(k, LW);
		assign ln_tab[k] = V;
	end

	logic signed [15:0] o_q, e_q;
	logic signed [16:0] d_q;
	logic               last_q, csat_q, lsel_q;
	logic [DW-1:0]      den_q;
	logic [LW-1:0]      ridx_q;
	logic [3:0]         p_q;
	logic [31:0]        rom_q;
	logic [NLW-1:0]     nla_q, nlb_q;
	logic signed [P1W-1:0] p1_q;
	logic signed [P2W-1:0] p2_q;
	logic signed [47:0] term_q;
	logic signed [31:0] grad_q;
	logic               gsat_q;
	logic [COST_W-1:0]  acc_q;
	logic               sticky_q;

	logic               out_valid_q;
	logic signed [31:0] out_grad_q;
	logic               out_gsat_q, out_dom_q, out_last_q;
	logic [COST_W-1:0]  out_cost_q;

	logic               out_load;
	logic               div_done;
	logic [QW-1:0]      div_quo;
	logic [16:0]        absd;
	logic [NW-1:0]      mag;
	logic [F-1:0]       lx;
	logic [F:0]         omo;
	logic [3:0]         lp;
	logic [F+14:0]      lsh;
	logic [35:0]        lval, lrnd;
	logic [33:0]        sq;
	logic signed [SW-1:0] s_sum;
	logic [SW-1:0]      s_mag;
	logic signed [17:0] ome;
	logic signed [48:0] acc_sum;
	logic [COST_W-1:0]  acc_new;

	assign absd = d_q[16] ? 17'(-d_q) : 17'(d_q);
	assign mag  = {absd, {(2 * F){1'b0}}};
	assign omo  = (F + 1)'(1 << F) - {1'b0, o_q[F-1:0]};
	assign lx   = lsel_q ? omo[F-1:0] : o_q[F-1:0];

	always_comb begin
		lp = '0;
		for (int i = 0; i < F; i++) begin
			if (lx[i]) begin
				lp = 4'(i);
			end
		end
	end

	assign lsh   = {lx, 15'b0} >> lp;
	assign lval  = 36'(4'(F) - p_q) * 36'(LN2_Q32) - 36'(rom_q);
	assign lrnd  = (lval + (36'd1 << (31 - F))) >> (32 - F);
	assign sq    = 34'($signed(d_q) * $signed(d_q));
	assign ome   = 18'(1 << F) - 18'(e_q);
	assign s_sum = SW'(p1_q) + SW'(p2_q);
	assign s_mag = s_sum[SW-1] ? SW'(-s_sum) : SW'(s_sum);
	assign acc_sum = $signed({2'b00, acc_q}) + $signed({term_q[47], term_q});

	always_comb begin
		if (csat_q || (acc_sum > $signed({2'b00, COST_MAX}))) begin
			acc_new = COST_MAX;
		end else if (acc_sum < 49'sd0) begin
			acc_new = '0;
		end else begin
			acc_new = acc_sum[COST_W-1:0];
		end
	end

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign out_load = (state_q == S_ACC) && (!out_valid_q || pop);

	lgu_div #(.NW(NW), .DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIVGO),
		.dividend (mag),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			sticky_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						if (!q_item.mode) begin
							state_q <= S_SQ;
						end else if (q_item.dom) begin
							state_q  <= S_ACC;
							sticky_q <= 1'b1;
						end else begin
							state_q <= S_DEN;
						end
					end
				end
				S_SQ:    state_q <= S_ACC;
				S_DEN:   state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_LIDX;
					end
				end
				S_LIDX:  state_q <= S_LROM;
				S_LROM:  state_q <= S_LNL;
				S_LNL:   state_q <= lsel_q ? S_MUL : S_LIDX;
				S_MUL:   state_q <= S_SUM;
				S_SUM:   state_q <= S_ACC;
				S_ACC: begin
					if (out_load) begin
						state_q  <= S_IDLE;
						acc_q    <= last_q ? '0 : acc_new;
						sticky_q <= last_q ? 1'b0 : sticky_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				o_q    <= q_item.o;
				e_q    <= q_item.e;
				d_q    <= 17'(q_item.o) - 17'(q_item.e);
				last_q <= q_item.last;
				csat_q <= q_item.mode && q_item.dom;
				lsel_q <= 1'b0;
				term_q <= '0;
				if (q_item.o > q_item.e) begin
					grad_q <= 32'sh7FFF_FFFF;
					gsat_q <= 1'b1;
				end else if (q_item.o < q_item.e) begin
					grad_q <= 32'sh8000_0000;
					gsat_q <= 1'b1;
				end else begin
					grad_q <= '0;
					gsat_q <= 1'b0;
				end
			end
			S_SQ: begin
				grad_q <= 32'(d_q);
				gsat_q <= 1'b0;
				term_q <= 48'(sq >> (F + 1));
			end
			S_DEN: begin
				den_q <= DW'(omo[F-1:0] * o_q[F-1:0]);
			end
			S_DIV: begin
				if (div_done) begin
					if (!d_q[16]) begin
						if (64'(div_quo) > 64'h7FFF_FFFF) begin
							grad_q <= 32'sh7FFF_FFFF;
							gsat_q <= 1'b1;
						end else begin
							grad_q <= 32'(div_quo);
							gsat_q <= 1'b0;
						end
					end else begin
						if (64'(div_quo) > 64'h8000_0000) begin
							grad_q <= 32'sh8000_0000;
							gsat_q <= 1'b1;
						end else begin
							grad_q <= -(32'(div_quo));
							gsat_q <= 1'b0;
						end
					end
				end
			end
			S_LIDX: begin
				ridx_q <= lsh[14 -: LW];
				p_q    <= lp;
			end
			S_LROM: begin
				rom_q <= ln_tab[ridx_q];
			end
			S_LNL: begin
				if (lsel_q) begin
					nlb_q <= NLW'(lrnd);
				end else begin
					nla_q <= NLW'(lrnd);
				end
				lsel_q <= 1'b1;
			end
			S_MUL: begin
				p1_q <= P1W'(e_q * $signed({1'b0, nla_q}));
				p2_q <= P2W'(ome * $signed({1'b0, nlb_q}));
			end
			S_SUM: begin
				term_q <= s_sum[SW-1] ? -(48'(s_mag >> F)) : 48'(s_mag >> F);
			end
			S_ACC: begin
				if (out_load) begin
					out_grad_q <= grad_q;
					out_gsat_q <= gsat_q;
					out_dom_q  <= sticky_q;
					out_last_q <= last_q;
					out_cost_q <= last_q ? acc_new : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign empty              = !out_valid_q;
	assign gradient           = out_grad_q;
	assign gradient_saturated = out_gsat_q;
	assign domain_error       = out_dom_q;
	assign cost_total         = out_cost_q;
	assign cost_last          = out_last_q;
endmodule

FILE: hdl/loss_and_gradient_unit.sv
// Loss and gradient unit top level: quadratic and cross-entropy cost with gradient.
// The back part takes one word at a time: quadratic words pass through the square step,
// cross-entropy words with output outside (0,1) go straight to accumulation, and other
// cross-entropy words run the divider and two log lookups. A two-entry input queue and
// the result register let intake and delivery stall independently.
// Reset: asynchronous, clears mode, cost accumulator, domain flag and queues.
module loss_and_gradient_unit #(
	parameter int FRAC_BITS   = lgu_pkg::FRAC_BITS_DEF,
	parameter int LOG_ENTRIES = lgu_pkg::LOG_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [15:0]           output_value,
	input  logic signed [15:0]           expected_value,
	input  logic                         last_item,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_wr_data,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [31:0]           gradient,
	output logic                         gradient_saturated,
	output logic                         domain_error,
	output logic [lgu_pkg::COST_W-1:0]   cost_total,
	output logic                         cost_last
);
	import lgu_pkg::*;

	item_t q_item;
	logic  q_pop, q_empty;

	lgu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.output_value   (output_value),
		.expected_value (expected_value),
		.last_item      (last_item),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.q_pop          (q_pop),
		.q_empty        (q_empty),
		.q_item         (q_item)
	);

	lgu_back #(.FRAC_BITS(FRAC_BITS), .LOG_ENTRIES(LOG_ENTRIES)) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_empty            (q_empty),
		.q_item             (q_item),
		.q_pop              (q_pop),
		.empty              (empty),
		.pop                (pop),
		.gradient           (gradient),
		.gradient_saturated (gradient_saturated),
		.domain_error       (domain_error),
		.cost_total         (cost_total),
		.cost_last          (cost_last)
	);
endmodule

FILE: hdl/lgu_checker.sv
// Port-level checks of the loss and gradient unit and their bind.
`include "loss_and_gradient_unit_macros.svh"

module lgu_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         empty,
	input logic                         pop,
	input logic signed [31:0]           gradient,
	input logic                         gradient_saturated,
	input logic [lgu_pkg::COST_W-1:0]   cost_total,
	input logic                         cost_last
);
	`LGU_ASSERT_NXT(a_word_holds, clk, arst_n, !empty && !pop, !empty)
	`LGU_ASSERT_NXT(a_grad_stable, clk, arst_n, !empty && !pop, $stable(gradient))
	`LGU_ASSERT_IMP(a_cost_zero, clk, arst_n, !empty && !cost_last, cost_total == '0)
	`LGU_ASSERT_IMP(a_sat_limit, clk, arst_n, !empty && gradient_saturated,
		(gradient == 32'sh7FFF_FFFF) || (gradient == 32'sh8000_0000))
endmodule

bind loss_and_gradient_unit lgu_checker u_lgu_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the loss and gradient unit: quadratic and cross-entropy modes.
module testbench;
	import lgu_pkg::*;

	localparam int FB     = FRAC_BITS_DEF;
	localparam int NLOG   = LOG_ENTRIES_DEF;
	localparam longint ONE = longint'(1) << FB;
	localparam longint COST_SAT = (longint'(1) << COST_W) - 1;
	localparam int LIMIT  = 600000;

	typedef struct {
		logic [31:0]       grad;
		bit                gsat;
		bit                dom;
		logic [COST_W-1:0] cost;
		bit                last;
	} loss_word_t;

	class loss_scoreboard;
		loss_word_t  pending_q[$];
		bit [31:0]   ln_tab[NLOG];
		longint      cost_acc;
		bit          dom_flag;
		bit          mode;
		int          errors;

		function new();
			bit [63:0] y;
			bit [63:0] lg;
			for (int k = 0; k < NLOG; k++) begin
				y  = (64'd1 << 30) + ((64'(2 * k + 1) << 30) / 64'(2 * NLOG));
				lg = 0;
				for (int i = 0; i < 32; i++) begin
					y  = (y * y) >> 30;
					lg = lg << 1;
					if (y >= (64'd2 << 30)) begin
						y  = y >> 1;
						lg = lg | 64'd1;
					end
				end
				ln_tab[k] = 32'((lg * LN2_Q32 + (64'd1 << 31)) >> 32);
			end
			cost_acc = 0;
			dom_flag = 0;
			mode     = 0;
			errors   = 0;
		endfunction

		// -ln(x/ONE), 0 < x < ONE
		function longint neg_ln(longint x);
			int        p;
			bit [63:0] fq;
			bit [63:0] idx;
			bit [63:0] v;
			p = 0;
			while (p < 15 && (x >> (p + 1)) != 0)
				p++;
			fq  = 64'(x - (longint'(1) << p)) << (15 - p);
			idx = (fq * NLOG) >> 15;
			if (idx >= NLOG)
				idx = NLOG - 1;
			v = 64'(FB - p) * LN2_Q32 - 64'(ln_tab[idx]);
			return longint'((v + (64'd1 << (31 - FB))) >> (32 - FB));
		endfunction

		function void note_word(longint o, longint e, bit last);
			longint     d;
			longint     grad;
			longint     term;
			longint     s;
			longint     acc;
			bit         gsat;
			bit         csat;
			bit [63:0]  den;
			bit [63:0]  mag;
			bit [63:0]  q;
			loss_word_t w;
			d = o - e;
			grad = 0;
			term = 0;
			gsat = 0;
			csat = 0;
			if (!mode) begin
				grad = d;
				term = (d * d) >>> (FB + 1);
			end else if (o <= 0 || o >= ONE) begin
				dom_flag = 1;
				csat = 1;
				if (d > 0) begin
					grad = 32'sh7fffffff;
					gsat = 1;
				end else if (d < 0) begin
					grad = -longint'(64'h80000000);
					gsat = 1;
				end
			end else begin
				den = 64'((ONE - o) * o);
				mag = 64'(d < 0 ? -d : d) << (2 * FB);
				q = mag / den;
				if (d >= 0) begin
					if (q > 64'h7fffffff) begin
						grad = 64'h7fffffff;
						gsat = 1;
					end else
						grad = longint'(q);
				end else begin
					if (q > 64'h80000000) begin
						grad = -longint'(64'h80000000);
						gsat = 1;
					end else
						grad = -longint'(q);
				end
				s = e * neg_ln(o) + (ONE - e) * neg_ln(ONE - o);
				term = s >= 0 ? (s >>> FB) : -((-s) >>> FB);
			end
			if (csat)
				acc = COST_SAT;
			else begin
				acc = cost_acc + term;
				if (acc < 0)
					acc = 0;
				if (acc > COST_SAT)
					acc = COST_SAT;
			end
			cost_acc = acc;
			w.grad = grad[31:0];
			w.gsat = gsat;
			w.dom  = dom_flag;
			w.cost = last ? acc[COST_W-1:0] : '0;
			w.last = last;
			pending_q.push_back(w);
			if (last) begin
				cost_acc = 0;
				dom_flag = 0;
			end
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_word(logic [31:0] grad, logic gsat, logic dom, logic [COST_W-1:0] cost,
				logic last);
			loss_word_t w;
			if (pending_q.size() == 0) begin
				report("unexpected word");
				return;
			end
			w = pending_q.pop_front();
			if (grad !== w.grad)
				report($sformatf("gradient %h want %h", grad, w.grad));
			if (gsat !== w.gsat)
				report($sformatf("gradient_saturated %b want %b", gsat, w.gsat));
			if (dom !== w.dom)
				report($sformatf("domain_error %b want %b", dom, w.dom));
			if (cost !== w.cost)
				report($sformatf("cost_total %h want %h", cost, w.cost));
			if (last !== w.last)
				report($sformatf("cost_last %b want %b", last, w.last));
		endtask
	endclass

	logic                      clk = 0;
	logic                      arst_n = 0;
	logic                      push = 0;
	logic                      full;
	logic signed [15:0]        output_value = 0;
	logic signed [15:0]        expected_value = 0;
	logic                      last_item = 0;
	logic                      cfg_wr_en = 0;
	logic                      cfg_wr_data = 0;
	logic                      empty;
	logic                      pop = 0;
	logic signed [31:0]        gradient;
	logic                      gradient_saturated;
	logic                      domain_error;
	logic [COST_W-1:0]         cost_total;
	logic                      cost_last;

	loss_scoreboard sb;
	bit             calm = 0;
	int             cycles = 0;

	loss_and_gradient_unit u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.output_value(output_value), .expected_value(expected_value),
		.last_item(last_item), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.empty(empty), .pop(pop), .gradient(gradient),
		.gradient_saturated(gradient_saturated), .domain_error(domain_error),
		.cost_total(cost_total), .cost_last(cost_last)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			pop <= calm || ($urandom_range(99) >= 24);
	end

	always @(negedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_word(gradient, gradient_saturated, domain_error, cost_total, cost_last);
	end

	task send_word(logic signed [15:0] o, logic signed [15:0] e, logic l);
		bit taken;
		if (!calm) begin
			while ($urandom_range(99) < 24) begin
				push <= 0;
				@(posedge clk);
			end
		end
		push           <= 1;
		output_value   <= o;
		expected_value <= e;
		last_item      <= l;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		sb.note_word(o, e, l);
	endtask

	task drain();
		push <= 0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	task set_mode(bit m);
		drain();
		cfg_wr_en   <= 1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en   <= 0;
		sb.mode = m;
	endtask

	task random_phase(bit m, int n);
		int               len;
		int               sel;
		logic signed [15:0] o;
		logic signed [15:0] e;
		while (n > 0) begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				sel = $urandom_range(99);
				o = 16'($urandom);
				e = 16'($urandom);
				if (m && sel < 80) begin
					o = 16'($urandom_range(1, 32'(ONE - 1)));
					e = 16'($urandom_range(0, 32'(ONE)));
				end else if (m && sel < 86) begin
					case ($urandom_range(2))
						0: o = 0;
						1: o = 16'(ONE);
						default: o = -16'sd1 - 16'($urandom_range(100));
					endcase
				end else if (!m && sel < 50) begin
					o = 16'($urandom_range(0, 32'(2 * ONE)));
					e = 16'($urandom_range(0, 32'(ONE)));
				end
				send_word(o, e, i == len - 1);
				n--;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// quadratic extremes, reset mode
		send_word(16'sh7fff, -16'sh8000, 0);
		send_word(-16'sh8000, 16'sh7fff, 0);
		send_word(0, 0, 0);
		send_word(16'sh7fff, 16'sh7fff, 1);
		send_word(-16'sh8000, 16'sh7fff, 1);

		// cross-entropy: domain cases, edges, mode change mid-vector
		set_mode(1);
		send_word(16'sd100, 16'sd0, 0);
		set_mode(0);
		send_word(16'sd300, 16'sd4096, 0);
		set_mode(1);
		send_word(0, 16'sd4096, 1);
		send_word(16'sd4096, 0, 1);
		send_word(16'sd4096, 16'sd4096, 1);
		send_word(-16'sh8000, 16'sh7fff, 1);
		send_word(16'sh7fff, -16'sh8000, 1);
		send_word(16'sd1, 16'sd4096, 0);
		send_word(16'sd4095, 16'sd0, 0);
		send_word(16'sd1, -16'sh8000, 0);
		send_word(16'sd4095, 16'sh7fff, 1);
		send_word(16'sd2048, 16'sd2048, 0);
		send_word(16'sd2048, -16'sd5000, 1);
		send_word(16'sd1, 16'sd1, 1);

		for (int ph = 0; ph < 8; ph++) begin
			set_mode(ph[0]);
			calm = (ph == 3);
			random_phase(ph[0], 130);
		end
		calm = 0;

		drain();
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
